[hw/rtl/text_console_writer_unit_macros.svh]
// Assertion macros used by the console writer checker
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define TCW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies another one in the same cycle
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
   `TCW_ASSERT(lbl, (ante) |-> (cons), msg)

// Check that a condition implies another one in the next cycle
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
   `TCW_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[hw/rtl/tcw_pkg.sv]
// Shared constants and types of the text console writer
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
   localparam int CELL_AW    = $clog2(CELL_COUNT);

   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = 16;
   localparam int INDEX_W = 11;

   localparam logic              OP_PUT       = 1'b0;
   localparam logic              OP_READ      = 1'b1;
   localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'd10;
   localparam logic [CHAR_W-1:0] BLANK_BYTE   = 8'd32;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
   localparam logic [CELL_W-1:0] CLEAR_CELL   = {RESET_ATTR, BLANK_BYTE};

   localparam logic [CELL_AW-1:0] LAST_CELL   = CELL_AW'(CELL_COUNT - 1);
   localparam logic [CELL_AW-1:0] COPY_LAST   = CELL_AW'(COPY_COUNT);
   localparam logic [CELL_AW-1:0] ROW_STRIDE  = CELL_AW'(COLUMNS);
   localparam logic [CELL_AW-1:0] LAST_COLUMN = CELL_AW'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]   LAST_ROW    = ROW_W'(ROWS - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_COPY  = 5'b01000,
      ST_BLANK = 5'b10000
   } state_type;

endpackage

[hw/rtl/tcw_req_if.sv]
// Request channel of the text console writer
interface tcw_req_if
   import tcw_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [CHAR_W-1:0]  character;
   logic [INDEX_W-1:0] cell_index;

   modport source (output valid, operation, character, cell_index, input ready);
   modport sink   (input valid, operation, character, cell_index, output ready);
endinterface

[hw/rtl/tcw_rsp_if.sv]
// Response channel of the text console writer
interface tcw_rsp_if
   import tcw_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  cursor_column;
   logic [ROW_W-1:0]  cursor_row;
   logic              scrolled;
   logic [CELL_W-1:0] cell_data;

   modport source (output valid, cursor_column, cursor_row, scrolled, cell_data,
                   input ready);
   modport sink   (input valid, cursor_column, cursor_row, scrolled, cell_data,
                   output ready);
endinterface

[hw/rtl/tcw_csr_if.sv]
// Attribute register write channel of the text console writer
interface tcw_csr_if
   import tcw_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] text_attribute;

   modport source (output valid, text_attribute, input ready);
   modport sink   (input valid, text_attribute, output ready);
endinterface

[hw/rtl/text_console_writer_unit.sv]
// Text console writer: cursor logic, cell memory and scroll sequencer
// Usage:
//   req_bus carries one beat per item: operation 0 puts a character at the
//   cursor (byte 10 is a newline), operation 1 reads the cell at cell_index.
//   rsp_bus returns one beat per item with the cursor after the item, a
//   scroll flag and, for reads, the cell (attribute high, character low).
//   csr_bus writes the text attribute; it is always ready and is meant to be
//   written while no item is in flight.
// Throughput:
//   A put or newline that does not scroll has its response beat registered
//   at the accept edge, so such items stream at one per cycle while rsp_bus
//   is ready. A read passes the registered read port of the memory and then
//   the response register. A scroll copies COLUMNS*(ROWS-1) cells through
//   the memory's read and write ports, one per cycle, then blanks one row,
//   and req_bus is not ready until it is done.
// Reset: homes the cursor, sets the attribute to 0x07 and starts a clearing
//   pass that writes 0x0720 to every cell. No item is taken during that
//   pass; attribute writes are.
// Stall: the response beat holds while rsp_bus is stalled, and a new item
//   is only taken in the cycle in which the pending beat drains.
module text_console_writer_unit
   import tcw_pkg::*;
(
   input logic      clock,
   input logic      reset,
   tcw_req_if.sink  req_bus,
   tcw_rsp_if.source rsp_bus,
   tcw_csr_if.sink  csr_bus
);

   state_type           state_ff, state_in;
   logic [CELL_AW-1:0]  cnt_ff, cnt_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ATTR_W-1:0]   attr_ff;
   logic                rd_ok_ff, rd_ok_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic                rsp_scr_ff, rsp_scr_in;
   logic [CELL_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [CELL_W-1:0]   mem [CELL_COUNT];
   logic [CELL_W-1:0]   rd_data_ff;
   logic                mem_we;
   logic [CELL_AW-1:0]  mem_waddr;
   logic [CELL_AW-1:0]  mem_raddr;
   logic [CELL_W-1:0]   mem_wdata;

   logic                req_fire;
   logic                is_newline;
   logic [COL_W:0]      col_inc;
   logic                advance_row;
   logic                do_scroll;
   logic [CELL_AW-1:0]  cursor_addr;

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.cursor_column = rsp_col_ff;
   assign rsp_bus.cursor_row    = rsp_row_ff;
   assign rsp_bus.scrolled      = rsp_scr_ff;
   assign rsp_bus.cell_data     = rsp_data_ff;

   assign is_newline  = (req_bus.character == NEWLINE_BYTE);
   assign col_inc     = {1'b0, col_ff} + (COL_W + 1)'(1);
   assign advance_row = (req_bus.operation == OP_PUT)
                        && (is_newline || (col_inc == (COL_W + 1)'(COLUMNS)));
   assign do_scroll   = advance_row && (row_ff == LAST_ROW);
   assign cursor_addr = CELL_AW'(row_ff) * ROW_STRIDE + CELL_AW'(col_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_scr_in   = rsp_scr_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_raddr    = req_bus.cell_index[CELL_AW-1:0];
      mem_wdata    = CLEAR_CELL;

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + CELL_AW'(1);
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.operation == OP_READ) begin
                  rd_ok_in = (req_bus.cell_index < INDEX_W'(CELL_COUNT));
                  state_in = ST_READ;
               end else begin
                  mem_we    = !is_newline;
                  mem_waddr = cursor_addr;
                  mem_wdata = {attr_ff, req_bus.character};
                  if (advance_row) begin
                     col_in = '0;
                     if (!do_scroll) begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end else begin
                     col_in = col_inc[COL_W-1:0];
                  end
                  if (do_scroll) begin
                     cnt_in   = '0;
                     state_in = ST_COPY;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_col_in   = advance_row ? '0 : col_inc[COL_W-1:0];
                     rsp_row_in   = advance_row ? row_ff + ROW_W'(1) : row_ff;
                     rsp_scr_in   = 1'b0;
                     rsp_data_in  = '0;
                  end
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = col_ff;
            rsp_row_in   = row_ff;
            rsp_scr_in   = 1'b0;
            rsp_data_in  = rd_ok_ff ? rd_data_ff : '0;
            state_in     = ST_IDLE;
         end
         ST_COPY: begin
            // read one row below, write the cell fetched on the previous cycle
            mem_raddr = (cnt_ff == COPY_LAST) ? '0 : cnt_ff + ROW_STRIDE;
            mem_we    = (cnt_ff != '0);
            mem_waddr = cnt_ff - CELL_AW'(1);
            mem_wdata = rd_data_ff;
            cnt_in    = cnt_ff + CELL_AW'(1);
            if (cnt_ff == COPY_LAST) begin
               cnt_in   = '0;
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = COPY_LAST + cnt_ff;
            mem_wdata = {attr_ff, BLANK_BYTE};
            cnt_in    = cnt_ff + CELL_AW'(1);
            if (cnt_ff == LAST_COLUMN) begin
               cnt_in       = '0;
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_col_in   = '0;
               rsp_row_in   = LAST_ROW;
               rsp_scr_in   = 1'b1;
               rsp_data_in  = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            attr_ff <= csr_bus.text_attribute;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff    <= rd_ok_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_scr_ff  <= rsp_scr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

endmodule

[hw/rtl/tcw_checker.sv]
// Port-level checker of the text console writer and its bind
`include "text_console_writer_unit_macros.svh"

module tcw_checker
   import tcw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [COL_W-1:0]  rsp_column,
   input logic [ROW_W-1:0]  rsp_row,
   input logic              rsp_scrolled,
   input logic [CELL_W-1:0] rsp_data
);

   `TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response beat dropped while stalled")
   `TCW_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data) && $stable(rsp_row), "stalled response beat changed")
   `TCW_ASSERT_IMPL(a_scroll_home, rsp_valid && rsp_scrolled, rsp_row == LAST_ROW && rsp_column == '0, "scroll beat does not leave the cursor at the start of the last row")
   `TCW_ASSERT_IMPL(a_clear_busy, $past(reset), !req_ready, "item taken before the clearing pass")

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_column   (rsp_bus.cursor_column),
   .rsp_row      (rsp_bus.cursor_row),
   .rsp_scrolled (rsp_bus.scrolled),
   .rsp_data     (rsp_bus.cell_data)
);
